// ===== hdl/button_click_classifier_core_assert.svh =====
// Assertion macros shared by the button click classifier modules.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH

// Condition must never hold outside reset.
`define BCC_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("bcc: forbidden condition seen");

// Antecedent in one cycle implies consequent in the same cycle.
`define BCC_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bcc: implication violated");

// Antecedent in one cycle implies consequent in the next cycle.
`define BCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bcc: next-cycle implication violated");

`endif

// ===== hdl/bcc_pkg.sv =====
// ---------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the button click classifier modules.
// ---------------------------------------------------------------------------
package bcc_pkg;

   localparam int NUM_KEYS    = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int KEY_W  = 2;
   localparam int CODE_W = 3;
   localparam int CNT_W  = 2;
   localparam int TICK_W = 16;
   localparam int CSR_IDX_W = 2;

   // event codes
   localparam logic [CODE_W-1:0] EV_SINGLE  = 3'd0;
   localparam logic [CODE_W-1:0] EV_DOUBLE  = 3'd1;
   localparam logic [CODE_W-1:0] EV_TRIPLE  = 3'd2;
   localparam logic [CODE_W-1:0] EV_LONG    = 3'd3;
   localparam logic [CODE_W-1:0] EV_DOWN    = 3'd4;
   localparam logic [CODE_W-1:0] EV_ENDDOWN = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TIMEOUT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIMEOUT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION_LIMIT = 2'd2;

   localparam logic [TICK_W-1:0] SHORT_TIMEOUT_RST  = 16'd30;
   localparam logic [TICK_W-1:0] LONG_TIMEOUT_RST   = 16'd100;
   localparam logic [TICK_W-1:0] DURATION_LIMIT_RST = 16'd1000;

   localparam logic [CNT_W-1:0] TRIPLE_COUNT = 2'd3;
   localparam logic [CNT_W-1:0] DOUBLE_COUNT = 2'd2;

   typedef struct packed {
      logic             cmd;
      logic [KEY_W-1:0] key;
      logic             pressed;
      logic             new_mode;
      logic             clear_lock;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]  event_key;
      logic [CODE_W-1:0] event_code;
   } rsp_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic    valid;
      req_type item;
   } head_type;

   typedef struct packed {
      logic [TICK_W-1:0] short_timeout;
      logic [TICK_W-1:0] long_timeout;
      logic [TICK_W-1:0] duration_limit;
   } cfg_type;

endpackage

// ===== hdl/bcc_front.sv =====
// ---------------------------------------------------------------------------
// bcc_front
// Request intake: drops requests for absent keys and queues the rest.
// ---------------------------------------------------------------------------
`include "button_click_classifier_core_assert.svh"

module bcc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bcc_pkg::req_type   req_data,
   input  logic               pop,
   output bcc_pkg::head_type  head
);

   bcc_pkg::req_type                 entries_ff [bcc_pkg::QUEUE_DEPTH];
   logic [bcc_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bcc_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bcc_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             accept;
   logic                             key_ok;
   logic                             push;
   logic                             do_pop;

   assign req_stall = (count_ff == bcc_pkg::QCNT_W'(bcc_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign key_ok    = int'(req_data.key) < bcc_pkg::NUM_KEYS;
   // requests for keys that do not exist are taken and discarded
   assign push      = accept && key_ok;
   assign do_pop    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bcc_pkg::QPTR_W'(bcc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : bcc_pkg::QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == bcc_pkg::QPTR_W'(bcc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : bcc_pkg::QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !do_pop) begin
         count_in = bcc_pkg::QCNT_W'(count_ff + 1'b1);
      end else if (!push && do_pop) begin
         count_in = bcc_pkg::QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= req_data;
      end
   end

   `BCC_ASSERT_NEVER(a_count_bound, count_ff > bcc_pkg::QCNT_W'(bcc_pkg::QUEUE_DEPTH))
   `BCC_ASSERT_NEVER(a_pop_empty, pop && (count_ff == '0))
   `BCC_ASSERT_NEXT(a_push_fills, push && !do_pop, count_ff != '0)

endmodule

// ===== hdl/bcc_back.sv =====
// ---------------------------------------------------------------------------
// bcc_back
// Per-key state update and event generation, with a registered result stage.
// ---------------------------------------------------------------------------
`include "button_click_classifier_core_assert.svh"

module bcc_back (
   input  logic               clock,
   input  logic               reset,
   input  bcc_pkg::cfg_type   cfg,
   input  bcc_pkg::head_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bcc_pkg::rsp_type   rsp_data
);

   localparam int NK = bcc_pkg::NUM_KEYS;

   logic                             prev_ff [NK];
   logic                             mode_ff [NK];
   logic                             lock_ff [NK];
   logic [bcc_pkg::CNT_W-1:0]        cnt_ff  [NK];
   logic [bcc_pkg::TICK_W-1:0]       hold_ff [NK];

   logic                             rsp_valid_ff, rsp_valid_in;
   bcc_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                             out_free;
   bcc_pkg::req_type                 it;

   // selected key state
   logic                             s_prev, s_mode, s_lock;
   logic [bcc_pkg::CNT_W-1:0]        s_cnt;
   logic [bcc_pkg::TICK_W-1:0]       s_hold;

   // updated key state
   logic                             n_prev, n_mode, n_lock;
   logic [bcc_pkg::CNT_W-1:0]        n_cnt;
   logic [bcc_pkg::TICK_W-1:0]       n_hold;
   logic                             ev;
   logic [bcc_pkg::CODE_W-1:0]       code;

   assign it       = head.item;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head.valid && out_free;

   always_comb begin
      s_prev = 1'b0;
      s_mode = 1'b0;
      s_lock = 1'b0;
      s_cnt  = '0;
      s_hold = '0;
      for (int k = 0; k < NK; k++) begin
         if (int'(it.key) == k) begin
            s_prev = prev_ff[k];
            s_mode = mode_ff[k];
            s_lock = lock_ff[k];
            s_cnt  = cnt_ff[k];
            s_hold = hold_ff[k];
         end
      end
   end

   always_comb begin
      n_prev = s_prev;
      n_mode = s_mode;
      n_lock = s_lock;
      n_cnt  = s_cnt;
      n_hold = s_hold;
      ev     = 1'b0;
      code   = bcc_pkg::EV_SINGLE;
      if (it.cmd) begin
         n_prev = 1'b0;
         n_lock = !it.clear_lock;
         n_cnt  = '0;
         n_hold = '0;
         n_mode = it.new_mode;
      end else if (s_mode) begin
         if (it.pressed) begin
            ev   = 1'b1;
            code = bcc_pkg::EV_DOWN;
         end else if (s_prev) begin
            // release ends up-down mode
            n_lock = 1'b0;
            n_cnt  = '0;
            n_hold = '0;
            n_mode = 1'b0;
            ev     = 1'b1;
            code   = bcc_pkg::EV_ENDDOWN;
         end
         n_prev = it.pressed;
      end else begin
         if (it.pressed != s_prev) begin
            n_hold = bcc_pkg::TICK_W'(1);
            if (!it.pressed) begin
               if (s_lock) begin
                  // release after a long press is swallowed
                  n_lock = 1'b0;
                  n_hold = '0;
               end else begin
                  n_cnt = bcc_pkg::CNT_W'(s_cnt + 1'b1);
               end
            end
         end else if ((s_hold != '0) && (s_hold < cfg.duration_limit)) begin
            n_hold = bcc_pkg::TICK_W'(s_hold + 1'b1);
         end

         if (n_cnt == bcc_pkg::TRIPLE_COUNT) begin
            ev     = 1'b1;
            code   = bcc_pkg::EV_TRIPLE;
            n_cnt  = '0;
            n_hold = '0;
         end else if ((n_hold > cfg.short_timeout) && !it.pressed) begin
            ev     = 1'b1;
            code   = (n_cnt == bcc_pkg::DOUBLE_COUNT) ? bcc_pkg::EV_DOUBLE
                                                       : bcc_pkg::EV_SINGLE;
            n_cnt  = '0;
            n_hold = '0;
         end else if ((n_hold > cfg.long_timeout) && it.pressed) begin
            ev     = 1'b1;
            code   = bcc_pkg::EV_LONG;
            n_cnt  = '0;
            n_hold = '0;
            n_lock = 1'b1;
         end
         n_prev = it.pressed;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = pop && ev;
         rsp_data_in.event_key  = it.key;
         rsp_data_in.event_code = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NK; k++) begin
            prev_ff[k] <= 1'b0;
            mode_ff[k] <= 1'b0;
            lock_ff[k] <= 1'b0;
            cnt_ff[k]  <= '0;
            hold_ff[k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < NK; k++) begin
            if (pop && (int'(it.key) == k)) begin
               prev_ff[k] <= n_prev;
               mode_ff[k] <= n_mode;
               lock_ff[k] <= n_lock;
               cnt_ff[k]  <= n_cnt;
               hold_ff[k] <= n_hold;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BCC_ASSERT_NEVER(a_cmd_no_event, pop && it.cmd && ev)
   `BCC_ASSERT_IMPLY(a_pop_needs_slot, pop, out_free && head.valid)
   `BCC_ASSERT_NEXT(a_event_shown, pop && ev, rsp_valid_ff)

endmodule

// ===== hdl/button_click_classifier_core.sv =====
// ---------------------------------------------------------------------------
// button_click_classifier_core
// Multi-click button classifier: single, double, triple, long and up-down.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one request per accepted cycle (req_valid high, req_stall low),
//            either a sample tick for a key or a mode-set command.
//   rsp_*  : zero or one event per request, taken when rsp_valid is high and
//            rsp_stall is low.
//   csr_*  : register writes (index 0 short timeout, 1 long timeout,
//            2 duration limit); csr_ready is always high.
// Path: a request is held in the request queue, then the back end updates
//   its key and writes any event into the registered result stage, which
//   drives rsp_valid.
// Throughput: one request per cycle while rsp_stall does not hold the back
//   end; key state is updated by a read-modify-write in the back end.
// Stalling: while rsp_stall is held the back end stops, the four-entry
//   request queue fills, and req_stall rises once it is full.
// Reset: all keys return to click mode, unlocked, counters zero; registers
//   return to 30, 100 and 1000.
// ---------------------------------------------------------------------------
module button_click_classifier_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bcc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bcc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bcc_pkg::TICK_W-1:0]        csr_data
);

   bcc_pkg::cfg_type   cfg_ff, cfg_in;
   bcc_pkg::head_type  head;
   logic               pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bcc_pkg::CSR_SHORT_TIMEOUT:  cfg_in.short_timeout  = csr_data;
            bcc_pkg::CSR_LONG_TIMEOUT:   cfg_in.long_timeout   = csr_data;
            bcc_pkg::CSR_DURATION_LIMIT: cfg_in.duration_limit = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_timeout  <= bcc_pkg::SHORT_TIMEOUT_RST;
         cfg_ff.long_timeout   <= bcc_pkg::LONG_TIMEOUT_RST;
         cfg_ff.duration_limit <= bcc_pkg::DURATION_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .head      (head)
   );

   bcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/button_click_classifier_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// button_click_classifier_core_tb
// Self-checking bench for the multi-click button classifier. A short scripted
// sequence walks every click kind, long press, lock and up-down mode; random
// button traffic then runs under a series of timeout settings, including the
// extremes. Every event is checked against scripted rows or an in-bench model.
// ---------------------------------------------------------------------------
module button_click_classifier_core_tb;

   localparam int LIMIT_CYCLES = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int N_PHASES     = 7;
   localparam logic [bcc_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // not a register

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   bcc_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   bcc_pkg::rsp_type               rsp_data;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [bcc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bcc_pkg::TICK_W-1:0]     csr_data;

   button_click_classifier_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // key model
   logic [bcc_pkg::NUM_KEYS-1:0] last_level = '0;
   logic [bcc_pkg::NUM_KEYS-1:0] in_updown  = '0;
   logic [bcc_pkg::NUM_KEYS-1:0] lock_long  = '0;
   logic [bcc_pkg::CNT_W-1:0]    n_clicks  [bcc_pkg::NUM_KEYS] = '{default: '0};
   logic [bcc_pkg::TICK_W-1:0]   run_ticks [bcc_pkg::NUM_KEYS] = '{default: '0};
   logic [bcc_pkg::TICK_W-1:0]   cfg_short = bcc_pkg::SHORT_TIMEOUT_RST;
   logic [bcc_pkg::TICK_W-1:0]   cfg_long  = bcc_pkg::LONG_TIMEOUT_RST;
   logic [bcc_pkg::TICK_W-1:0]   cfg_limit = bcc_pkg::DURATION_LIMIT_RST;

   bcc_pkg::rsp_type pending_events [$];

   typedef struct {
      bcc_pkg::req_type req;
      bit               typed;
      bit               fires;
      bcc_pkg::rsp_type ev;
   } stim_row_type;
   stim_row_type script [$];

   // random button behaviour per key
   logic [bcc_pkg::NUM_KEYS-1:0] tgt_level = '0;
   int                           run_left [bcc_pkg::NUM_KEYS] = '{default: 0};
   int                           focus_key = 0;

   logic [bcc_pkg::TICK_W-1:0] ph_short [N_PHASES] =
      '{16'd3, 16'd30, 16'd65535, 16'd2, 16'd1, 16'd0, 16'd5};
   logic [bcc_pkg::TICK_W-1:0] ph_long  [N_PHASES] =
      '{16'd8, 16'd100, 16'd6, 16'd65535, 16'd2, 16'd0, 16'd12};
   logic [bcc_pkg::TICK_W-1:0] ph_limit [N_PHASES] =
      '{16'd1000, 16'd1000, 16'd65535, 16'd1, 16'd2, 16'd0, 16'd65535};
   int          ph_items [N_PHASES] = '{300, 400, 200, 200, 200, 150, 375};
   bit          ph_calm  [N_PHASES] = '{0, 0, 1, 0, 1, 0, 0};

   bit calm             = 1'b0;
   bit rsp_hold_pending = 1'b0;
   int mismatches       = 0;
   int requests_sent    = 0;
   int events_checked   = 0;
   int settings_used    = 0;
   int code_hits [8]    = '{default: 0};
   int cycle_count      = 0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   function automatic void clear_key(input int k, input bit mode, input bit clr);
      last_level[k] = 1'b0;
      lock_long[k]  = ~clr;
      n_clicks[k]   = '0;
      run_ticks[k]  = '0;
      in_updown[k]  = mode;
   endfunction

   // advances one key and says whether the request raises an event
   function automatic bit classify(input bcc_pkg::req_type r, output bcc_pkg::rsp_type ev);
      int  k;
      bit  fire;
      logic [bcc_pkg::CODE_W-1:0] code;
      k    = r.key;
      fire = 1'b0;
      code = bcc_pkg::EV_SINGLE;
      ev   = '0;
      if (k >= bcc_pkg::NUM_KEYS)
         return 1'b0;
      if (r.cmd) begin
         clear_key(k, r.new_mode, r.clear_lock);
         return 1'b0;
      end
      if (in_updown[k]) begin
         if (r.pressed) begin
            code = bcc_pkg::EV_DOWN;
            fire = 1'b1;
         end else if (last_level[k]) begin
            clear_key(k, 1'b0, 1'b1);
            code = bcc_pkg::EV_ENDDOWN;
            fire = 1'b1;
         end
      end else begin
         if (r.pressed != last_level[k]) begin
            run_ticks[k] = bcc_pkg::TICK_W'(1);
            if (!r.pressed) begin
               // release after a long press is swallowed
               if (lock_long[k]) begin
                  lock_long[k] = 1'b0;
                  run_ticks[k] = '0;
               end else begin
                  n_clicks[k] = n_clicks[k] + 1'b1;
               end
            end
         end else if (run_ticks[k] != '0 && run_ticks[k] < cfg_limit) begin
            run_ticks[k] = run_ticks[k] + 1'b1;
         end

         if (n_clicks[k] == bcc_pkg::TRIPLE_COUNT) begin
            code = bcc_pkg::EV_TRIPLE;
            fire = 1'b1;
            n_clicks[k]  = '0;
            run_ticks[k] = '0;
         end else if (run_ticks[k] > cfg_short && !r.pressed) begin
            code = (n_clicks[k] == bcc_pkg::DOUBLE_COUNT) ? bcc_pkg::EV_DOUBLE
                                                         : bcc_pkg::EV_SINGLE;
            fire = 1'b1;
            n_clicks[k]  = '0;
            run_ticks[k] = '0;
         end else if (run_ticks[k] > cfg_long && r.pressed) begin
            code = bcc_pkg::EV_LONG;
            fire = 1'b1;
            n_clicks[k]  = '0;
            run_ticks[k] = '0;
            lock_long[k] = 1'b1;
         end
      end
      last_level[k] = r.pressed;
      ev.event_key  = r.key;
      ev.event_code = code;
      return fire;
   endfunction

   function automatic void add_row(input bit c, input logic [bcc_pkg::KEY_W-1:0] k,
                                   input bit p, input bit m, input bit cl,
                                   input bit typed = 1'b0, input bit fires = 1'b0,
                                   input logic [bcc_pkg::CODE_W-1:0] code =
                                      bcc_pkg::EV_SINGLE);
      stim_row_type row;
      row.req   = '{cmd: c, key: k, pressed: p, new_mode: m, clear_lock: cl};
      row.typed = typed;
      row.fires = fires;
      row.ev    = '{event_key: k, event_code: code};
      script.push_back(row);
   endfunction

   function automatic int draw_run();
      int span;
      span = ($urandom_range(0, 2) == 0) ? int'(cfg_long) : int'(cfg_short);
      if (span > 150)
         span = 150;
      return $urandom_range(1, span + 2);
   endfunction

   // mostly clean press/release runs per key, some glitches and mode commands
   function automatic bcc_pkg::req_type random_request();
      bcc_pkg::req_type r;
      int k;
      r = bcc_pkg::req_type'(6'($urandom_range(0, 63)));
      if ($urandom_range(0, 9) < 6)
         r.key = bcc_pkg::KEY_W'(focus_key);
      r.cmd = ($urandom_range(0, 99) < 3);
      k = r.key;
      if (!r.cmd && $urandom_range(0, 99) >= 8) begin
         if (run_left[k] == 0) begin
            tgt_level[k] = ~tgt_level[k];
            run_left[k]  = draw_run();
         end
         run_left[k]--;
         r.pressed = tgt_level[k];
      end
      return r;
   endfunction

   task automatic send_req(input bcc_pkg::req_type r, input bit typed, input bit fires,
                           input bcc_pkg::rsp_type want);
      int gap;
      bit fired;
      bcc_pkg::rsp_type got;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      fired = classify(r, got);
      if (typed) begin
         if (fires)
            pending_events.push_back(want);
      end else if (fired) begin
         pending_events.push_back(got);
      end
      requests_sent++;
   endtask

   // no request in flight and every event delivered
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(input logic [bcc_pkg::TICK_W-1:0] s, l, d,
                               input bit poke_spare);
      logic [bcc_pkg::TICK_W-1:0] vals [4];
      int last;
      int i;
      vals[bcc_pkg::CSR_SHORT_TIMEOUT]  = s;
      vals[bcc_pkg::CSR_LONG_TIMEOUT]   = l;
      vals[bcc_pkg::CSR_DURATION_LIMIT] = d;
      vals[CSR_SPARE]                   = bcc_pkg::TICK_W'($urandom);
      last = poke_spare ? int'(CSR_SPARE) : int'(bcc_pkg::CSR_DURATION_LIMIT);
      for (i = 0; i <= last; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[bcc_pkg::CSR_IDX_W-1:0];
         csr_data  <= vals[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
         case (i[bcc_pkg::CSR_IDX_W-1:0])
            bcc_pkg::CSR_SHORT_TIMEOUT:  cfg_short = vals[i];
            bcc_pkg::CSR_LONG_TIMEOUT:   cfg_long  = vals[i];
            bcc_pkg::CSR_DURATION_LIMIT: cfg_limit = vals[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES)
         @(posedge clock);
      $display("** button_click_classifier_core: FAILED **");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin : result_sink
      int gap;
      rsp_stall <= 1'b1;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 9);
         if (rsp_hold_pending) begin
            gap = LONG_HOLD;
            rsp_hold_pending = 1'b0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   always @(posedge clock) begin : event_check
      bcc_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         events_checked++;
         code_hits[rsp_data.event_code]++;
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("event key %0d code %0d with none expected",
                                      rsp_data.event_key, rsp_data.event_code));
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.event_key !== want.event_key)
               report_mismatch($sformatf("event_key %0d, expected %0d",
                                         rsp_data.event_key, want.event_key));
            if (rsp_data.event_code !== want.event_code)
               report_mismatch($sformatf("event_code %0d, expected %0d (key %0d)",
                                         rsp_data.event_code, want.event_code,
                                         want.event_key));
         end
      end
   end

   initial begin : stimulus
      int p;
      int i;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single on key 0, double on 1, triple on 2, long then swallowed release on 3
      add_row(0, 0, 1, 0, 0);
      add_row(0, 0, 0, 1, 1);
      add_row(0, 0, 0, 0, 0);
      add_row(0, 1, 1, 1, 0);
      add_row(0, 1, 0, 0, 1);
      add_row(0, 1, 1, 0, 0);
      add_row(0, 1, 0, 1, 1);
      add_row(0, 1, 0, 0, 0);
      add_row(0, 2, 1, 0, 0);
      add_row(0, 2, 0, 0, 0);
      add_row(0, 2, 1, 1, 1);
      add_row(0, 2, 0, 0, 0);
      add_row(0, 2, 1, 0, 1);
      add_row(0, 2, 0, 1, 0);
      add_row(0, 3, 1, 0, 0);
      add_row(0, 3, 1, 0, 0);
      add_row(0, 3, 0, 1, 1);
      // up-down mode on key 3: idle release is silent, release after press ends it
      add_row(1, 3, 0, 1, 1, 1, 0);
      add_row(0, 3, 0, 0, 0, 1, 0);
      add_row(0, 3, 1, 0, 0, 1, 1, bcc_pkg::EV_DOWN);
      add_row(0, 3, 1, 1, 1, 1, 1, bcc_pkg::EV_DOWN);
      add_row(0, 3, 0, 0, 0, 1, 1, bcc_pkg::EV_ENDDOWN);
      // lock set by command swallows the next release
      add_row(1, 0, 1, 0, 0, 1, 0);
      add_row(0, 0, 1, 0, 0, 1, 0);
      add_row(0, 0, 0, 0, 0, 1, 0);

      program_regs(16'd1, 16'd1, 16'd1000, 1'b0);
      for (i = 0; i < script.size(); i++)
         send_req(script[i].req, script[i].typed, script[i].fires, script[i].ev);

      for (p = 0; p < N_PHASES; p++) begin
         settle();
         program_regs(ph_short[p], ph_long[p], ph_limit[p], p == N_PHASES - 1);
         calm      = ph_calm[p];
         focus_key = $urandom_range(0, bcc_pkg::NUM_KEYS - 1);
         if (p == 1)
            rsp_hold_pending = 1'b1;
         for (i = 0; i < ph_items[p]; i++) begin
            if (p == 0 && i == ph_items[p] / 2)
               settle();
            send_req(random_request(), 1'b0, 1'b0, '0);
         end
      end
      settle();

      $display("Covered %0d requests across %0d timeout settings; %0d events checked",
               requests_sent, settings_used, events_checked);
      $display("Events: single %0d double %0d triple %0d long %0d down %0d end-down %0d",
               code_hits[bcc_pkg::EV_SINGLE], code_hits[bcc_pkg::EV_DOUBLE],
               code_hits[bcc_pkg::EV_TRIPLE], code_hits[bcc_pkg::EV_LONG],
               code_hits[bcc_pkg::EV_DOWN], code_hits[bcc_pkg::EV_ENDDOWN]);
      if (mismatches == 0) begin
         $display("** button_click_classifier_core: PASSED **");
      end else begin
         $display("** button_click_classifier_core: FAILED **");
      end
      $finish;
   end

endmodule
